// ===== sv/ssbc_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI SRAM sector bank controller: shared types and constants
// Field widths, item and result layouts, codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssbc_pkg;

   localparam int MAX_CHIPS_DEF = 16;
   localparam int ADDR_BITS_DEF = 24;

   localparam int CHIP_SIZE_W   = 25;
   localparam int SECTOR_SIZE_W = 13;
   localparam int CHIP_COUNT_W  = 5;
   localparam int SECTOR_W      = 24;
   localparam int COUNT_W       = 16;
   localparam int CHIP_W        = 4;
   localparam int INFO_W        = 32;
   localparam int FUNC_W        = 3;
   localparam int ICMD_W        = 3;
   localparam int CSR_ADDR_W    = 2;
   localparam int CSR_DATA_W    = CHIP_SIZE_W;

   // divider operands: widest dividend is sector * sector_size
   localparam int PROD_W    = SECTOR_W + SECTOR_SIZE_W;
   localparam int DIVISOR_W = CHIP_SIZE_W;
   localparam int STEP_W    = $clog2(PROD_W + 1);

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;

   localparam logic [CHIP_SIZE_W-1:0]   CHIP_SIZE_RST   = 25'd131072;
   localparam logic [SECTOR_SIZE_W-1:0] SECTOR_SIZE_RST = 13'd512;
   localparam logic [CHIP_COUNT_W-1:0]  CHIP_COUNT_RST  = 5'd1;

   localparam logic [CSR_ADDR_W-1:0] CSR_CHIP_SIZE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SECTOR_SIZE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHIP_COUNT  = 2'd2;

   localparam logic [FUNC_W-1:0] FUNC_INIT  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DATA  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_IOCTL = 3'd4;

   localparam logic [ICMD_W-1:0] IOCTL_SYNC    = 3'd0;
   localparam logic [ICMD_W-1:0] IOCTL_SECTORS = 3'd1;
   localparam logic [ICMD_W-1:0] IOCTL_SSIZE   = 3'd2;
   localparam logic [ICMD_W-1:0] IOCTL_BSIZE   = 3'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_READY = 2'd1;
   localparam logic [1:0] ST_PARAM     = 2'd2;
   localparam logic [1:0] ST_BUSY      = 2'd3;

   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_WRITE = 8'h02;
   localparam logic [7:0] FILL_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      RES_STATUS,
      RES_INFO,
      RES_BUS,
      RES_HDR
   } res_kind_type;

   typedef enum logic {
      MUL_OFFSET,
      MUL_INFO
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_SPC,
      DIV_CHIP,
      DIV_OFFSET,
      DIV_INFO
   } div_sel_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [4:0]          pad;
      logic [ICMD_W-1:0]   ioctl_cmd;
      logic [7:0]          data_byte;
      logic [COUNT_W-1:0]  sector_count;
      logic [SECTOR_W-1:0] start_sector;
   } req_data_type;

   typedef struct packed {
      logic [6:0]        pad;
      logic [INFO_W-1:0] info_value;
      logic [1:0]        status;
      logic              read_valid;
      logic [7:0]        read_byte;
      logic              select_active;
      logic [CHIP_W-1:0] chip_index;
      logic              spi_valid;
      logic [7:0]        spi_byte;
   } rsp_data_type;

   typedef struct packed {
      logic         load;
      logic         emit;
      res_kind_type res_kind;
      logic [1:0]   res_status;
      logic         res_last;
      logic         clr_not_ready;
      logic         begin_req;
      logic         set_busy;
      logic         clr_busy;
      logic         byte_step;
      logic         sector_step;
      logic         mul_go;
      mul_sel_type  mul_sel;
      logic         div_go;
      div_sel_type  div_sel;
      logic         spc_load;
      logic         chip_load;
      logic         off_load;
      logic         hdr_dec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              busy;
      logic              not_ready;
      logic              count_zero;
      logic              info_div;
      logic              byte_end;
      logic              last_sector;
      logic              geom_bad;
      logic              quot_zero;
      logic              chip_out;
      logic              div_busy;
      logic              hdr_last;
      logic              out_free;
   } dp_sts_type;

endpackage

// ===== sv/ssbc_div.sv =====
// ----------------------------------------------------------------------------
// SPI SRAM sector bank controller: shared divider
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
module ssbc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic [ssbc_pkg::PROD_W-1:0]       dividend,
   input  logic [ssbc_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              busy,
   output logic [ssbc_pkg::PROD_W-1:0]       quotient,
   output logic [ssbc_pkg::DIVISOR_W-1:0]    remainder
);
   import ssbc_pkg::*;

   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic                 run_ff, run_in;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = STEP_W'(PROD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift in the next dividend bit, keep the quotient bit
         quo_in = {quo_ff[PROD_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         run_in = cnt_ff != STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = run_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/ssbc_dp.sv =====
// ----------------------------------------------------------------------------
// SPI SRAM sector bank controller: datapath
// Configuration, transfer state, sector mapping arithmetic and the result
// register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module ssbc_dp #(
   parameter int MAX_CHIPS = ssbc_pkg::MAX_CHIPS_DEF,
   parameter int ADDR_BITS = ssbc_pkg::ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ssbc_pkg::ctrl_cmd_type             cmd,
   output ssbc_pkg::dp_sts_type               sts,
   input  logic [ssbc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [ssbc_pkg::FUNC_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ssbc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [ssbc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ssbc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssbc_pkg::*;

   localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
   localparam int ADDR_PAD_W = 8 * ADDR_BYTES;
   localparam int HDR_IDX_W  = $clog2(ADDR_BYTES + 1);

   // configuration
   logic [CHIP_SIZE_W-1:0]   chip_size_ff, chip_size_in;
   logic [SECTOR_SIZE_W-1:0] sector_size_ff, sector_size_in;
   logic [CHIP_COUNT_W-1:0]  chip_count_ff, chip_count_in;

   // held input item
   req_data_type             item_ff, item_in;
   logic [FUNC_W-1:0]        func_ff, func_in;

   // transfer state
   logic                     not_ready_ff, not_ready_in;
   logic                     busy_ff, busy_in;
   logic                     is_write_ff, is_write_in;
   logic [SECTOR_W-1:0]      sector_ff, sector_in;
   logic [COUNT_W-1:0]       left_ff, left_in;
   logic [SECTOR_SIZE_W-1:0] byte_idx_ff, byte_idx_in;
   logic [CHIP_W-1:0]        chip_ff, chip_in;

   // mapping arithmetic
   logic [DIVISOR_W-1:0]     spc_ff, spc_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [ADDR_BITS-1:0]     off_ff, off_in;
   logic [HDR_IDX_W-1:0]     hdr_idx_ff, hdr_idx_in;

   // result register
   rsp_data_type             rsp_ff, rsp_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [CHIP_COUNT_W-1:0]  eff_chips;
   logic [PROD_W-1:0]        div_dividend;
   logic [DIVISOR_W-1:0]     div_divisor;
   logic                     div_busy;
   logic [PROD_W-1:0]        quotient;
   logic [DIVISOR_W-1:0]     remainder;
   logic                     byte_end;
   logic                     out_free;
   logic [ADDR_PAD_W-1:0]    addr_pad;
   logic [ADDR_PAD_W-1:0]    addr_shift;
   logic                     hdr_is_cmd;
   logic [INFO_W-1:0]        info_value;
   logic [1:0]               info_status;
   rsp_data_type             res;

   assign eff_chips = (chip_count_ff > CHIP_COUNT_W'(MAX_CHIPS))
                    ? CHIP_COUNT_W'(MAX_CHIPS) : chip_count_ff;

   assign byte_end = ({1'b0, byte_idx_ff} + (SECTOR_SIZE_W + 1)'(1))
                     >= {1'b0, sector_size_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ---- divider operand selection ----
   always_comb begin
      unique case (cmd.div_sel)
         DIV_SPC: begin
            div_dividend = PROD_W'(chip_size_ff);
            div_divisor  = DIVISOR_W'(sector_size_ff);
         end
         DIV_CHIP: begin
            div_dividend = PROD_W'(sector_ff);
            div_divisor  = spc_ff;
         end
         DIV_OFFSET: begin
            div_dividend = prod_ff;
            div_divisor  = chip_size_ff;
         end
         default: begin
            div_dividend = prod_ff;
            div_divisor  = DIVISOR_W'(sector_size_ff);
         end
      endcase
   end

   ssbc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // ---- header byte: command first, then offset most significant byte first ----
   assign addr_pad   = ADDR_PAD_W'(off_ff);
   assign addr_shift = addr_pad >> {hdr_idx_ff, 3'b000};
   assign hdr_is_cmd = hdr_idx_ff == HDR_IDX_W'(ADDR_BYTES);

   // ---- ioctl answer ----
   always_comb begin
      info_value = '0;
      case (item_ff.ioctl_cmd)
         IOCTL_SECTORS: info_value = (sector_size_ff == '0) ? '0 : quotient[INFO_W-1:0];
         IOCTL_SSIZE:   info_value = INFO_W'(sector_size_ff);
         IOCTL_BSIZE:   info_value = INFO_W'(1);
         default:       info_value = '0;
      endcase
      case (item_ff.ioctl_cmd) inside
         IOCTL_SYNC, IOCTL_SECTORS, IOCTL_SSIZE, IOCTL_BSIZE: info_status = ST_OK;
         default: info_status = ST_PARAM;
      endcase
   end

   // ---- result assembly ----
   always_comb begin
      res = '0;
      case (cmd.res_kind)
         RES_STATUS: res.status = cmd.res_status;
         RES_INFO: begin
            res.status     = info_status;
            res.info_value = info_value;
         end
         RES_BUS: begin
            res.spi_valid     = 1'b1;
            res.chip_index    = chip_ff;
            res.select_active = !byte_end;
            if (is_write_ff) begin
               res.spi_byte = item_ff.data_byte;
            end else begin
               res.spi_byte   = FILL_BYTE;
               res.read_byte  = item_ff.data_byte;
               res.read_valid = 1'b1;
            end
         end
         default: begin
            res.spi_valid     = 1'b1;
            res.chip_index    = chip_ff;
            res.select_active = 1'b1;
            if (hdr_is_cmd) begin
               res.spi_byte = is_write_ff ? CMD_WRITE : CMD_READ;
            end else begin
               res.spi_byte = addr_shift[7:0];
            end
         end
      endcase
   end

   // ---- next state ----
   always_comb begin
      chip_size_in   = chip_size_ff;
      sector_size_in = sector_size_ff;
      chip_count_in  = chip_count_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_CHIP_SIZE:   chip_size_in   = csr_wdata;
            CSR_SECTOR_SIZE: sector_size_in = csr_wdata[SECTOR_SIZE_W-1:0];
            CSR_CHIP_COUNT:  chip_count_in  = csr_wdata[CHIP_COUNT_W-1:0];
            default: ;
         endcase
      end

      item_in = cmd.load ? req_data_type'(req_tdata) : item_ff;
      func_in = cmd.load ? req_tuser : func_ff;

      not_ready_in = cmd.clr_not_ready ? 1'b0 : not_ready_ff;
      busy_in      = busy_ff;
      if (cmd.set_busy) begin
         busy_in = 1'b1;
      end else if (cmd.clr_busy) begin
         busy_in = 1'b0;
      end

      is_write_in = is_write_ff;
      sector_in   = sector_ff;
      left_in     = left_ff;
      byte_idx_in = byte_idx_ff;
      if (cmd.begin_req) begin
         is_write_in = func_ff == FUNC_WRITE;
         sector_in   = item_ff.start_sector;
         left_in     = item_ff.sector_count;
         byte_idx_in = '0;
      end else if (cmd.sector_step) begin
         sector_in   = sector_ff + SECTOR_W'(1);
         left_in     = left_ff - COUNT_W'(1);
         byte_idx_in = '0;
      end else if (cmd.byte_step) begin
         byte_idx_in = byte_idx_ff + SECTOR_SIZE_W'(1);
      end

      chip_in = cmd.chip_load ? quotient[CHIP_W-1:0] : chip_ff;
      spc_in  = cmd.spc_load ? quotient[DIVISOR_W-1:0] : spc_ff;
      off_in  = cmd.off_load ? remainder[ADDR_BITS-1:0] : off_ff;

      prod_in = prod_ff;
      if (cmd.mul_go) begin
         if (cmd.mul_sel == MUL_OFFSET) begin
            prod_in = PROD_W'(sector_ff * sector_size_ff);
         end else begin
            prod_in = PROD_W'(chip_size_ff * eff_chips);
         end
      end

      hdr_idx_in = hdr_idx_ff;
      if (cmd.off_load) begin
         hdr_idx_in = HDR_IDX_W'(ADDR_BYTES);
      end else if (cmd.hdr_dec) begin
         hdr_idx_in = hdr_idx_ff - HDR_IDX_W'(1);
      end

      rsp_in       = rsp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.emit) begin
         rsp_in       = res;
         rsp_last_in  = cmd.res_last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_size_ff   <= CHIP_SIZE_RST;
         sector_size_ff <= SECTOR_SIZE_RST;
         chip_count_ff  <= CHIP_COUNT_RST;
         not_ready_ff   <= 1'b1;
         busy_ff        <= 1'b0;
         is_write_ff    <= 1'b0;
         sector_ff      <= '0;
         left_ff        <= '0;
         byte_idx_ff    <= '0;
         chip_ff        <= '0;
         hdr_idx_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         chip_size_ff   <= chip_size_in;
         sector_size_ff <= sector_size_in;
         chip_count_ff  <= chip_count_in;
         not_ready_ff   <= not_ready_in;
         busy_ff        <= busy_in;
         is_write_ff    <= is_write_in;
         sector_ff      <= sector_in;
         left_ff        <= left_in;
         byte_idx_ff    <= byte_idx_in;
         chip_ff        <= chip_in;
         hdr_idx_ff     <= hdr_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      item_ff     <= item_in;
      func_ff     <= func_in;
      spc_ff      <= spc_in;
      prod_ff     <= prod_in;
      off_ff      <= off_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   // ---- status to the controller ----
   assign sts.func        = func_ff;
   assign sts.busy        = busy_ff;
   assign sts.not_ready   = not_ready_ff;
   assign sts.count_zero  = item_ff.sector_count == '0;
   assign sts.info_div    = (item_ff.ioctl_cmd == IOCTL_SECTORS) && (sector_size_ff != '0);
   assign sts.byte_end    = byte_end;
   assign sts.last_sector = left_ff == COUNT_W'(1);
   assign sts.geom_bad    = (sector_size_ff == '0) || (chip_size_ff == '0);
   assign sts.quot_zero   = quotient == '0;
   assign sts.chip_out    = quotient >= PROD_W'(eff_chips);
   assign sts.div_busy    = div_busy;
   assign sts.hdr_last    = hdr_idx_ff == '0;
   assign sts.out_free    = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/ssbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// SPI SRAM sector bank controller: controller
// Decodes each item and sequences sector mapping, header and result beats.
// ----------------------------------------------------------------------------
module ssbc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  ssbc_pkg::dp_sts_type    sts,
   output ssbc_pkg::ctrl_cmd_type  cmd
);
   import ssbc_pkg::*;

   localparam logic [3:0] S_IDLE          = 4'd0;
   localparam logic [3:0] S_DECIDE        = 4'd1;
   localparam logic [3:0] S_INFO_DIV      = 4'd2;
   localparam logic [3:0] S_INFO_WAIT     = 4'd3;
   localparam logic [3:0] S_LOC_SPC       = 4'd4;
   localparam logic [3:0] S_LOC_SPC_WAIT  = 4'd5;
   localparam logic [3:0] S_LOC_CHIP      = 4'd6;
   localparam logic [3:0] S_LOC_CHIP_WAIT = 4'd7;
   localparam logic [3:0] S_LOC_OFF_WAIT  = 4'd8;
   localparam logic [3:0] S_HDR           = 4'd9;
   localparam logic [3:0] S_FAIL          = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_kind = RES_STATUS;
      cmd.mul_sel  = MUL_OFFSET;
      cmd.div_sel  = DIV_SPC;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.func == FUNC_DATA) begin
               if (!sts.busy) begin
                  if (sts.out_free) begin
                     cmd.emit       = 1'b1;
                     cmd.res_status = ST_PARAM;
                     cmd.res_last   = 1'b1;
                     state_in       = S_IDLE;
                  end
               end else if (sts.out_free) begin
                  cmd.emit     = 1'b1;
                  cmd.res_kind = RES_BUS;
                  cmd.res_last = !sts.byte_end || sts.last_sector;
                  if (!sts.byte_end) begin
                     cmd.byte_step = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     cmd.sector_step = 1'b1;
                     if (sts.last_sector) begin
                        cmd.clr_busy = 1'b1;
                        state_in     = S_IDLE;
                     end else begin
                        state_in = S_LOC_SPC;
                     end
                  end
               end
            end else if (sts.busy) begin
               if (sts.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.res_status = ST_BUSY;
                  cmd.res_last   = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               unique case (sts.func) inside
                  FUNC_INIT: begin
                     if (sts.out_free) begin
                        cmd.emit          = 1'b1;
                        cmd.res_status    = ST_OK;
                        cmd.res_last      = 1'b1;
                        cmd.clr_not_ready = 1'b1;
                        state_in          = S_IDLE;
                     end
                  end
                  FUNC_READ, FUNC_WRITE: begin
                     if (sts.not_ready || sts.count_zero) begin
                        if (sts.out_free) begin
                           cmd.emit       = 1'b1;
                           cmd.res_status = sts.not_ready ? ST_NOT_READY : ST_OK;
                           cmd.res_last   = 1'b1;
                           state_in       = S_IDLE;
                        end
                     end else begin
                        cmd.begin_req = 1'b1;
                        state_in      = S_LOC_SPC;
                     end
                  end
                  FUNC_IOCTL: begin
                     if (sts.info_div) begin
                        cmd.mul_go  = 1'b1;
                        cmd.mul_sel = MUL_INFO;
                        state_in    = S_INFO_DIV;
                     end else if (sts.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.res_kind = RES_INFO;
                        cmd.res_last = 1'b1;
                        state_in     = S_IDLE;
                     end
                  end
                  default: begin
                     if (sts.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.res_status = ST_PARAM;
                        cmd.res_last   = 1'b1;
                        state_in       = S_IDLE;
                     end
                  end
               endcase
            end
         end
         S_INFO_DIV: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_INFO;
            state_in    = S_INFO_WAIT;
         end
         S_INFO_WAIT: begin
            cmd.div_sel = DIV_INFO;
            if (!sts.div_busy && sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.res_kind = RES_INFO;
               cmd.res_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LOC_SPC: begin
            if (sts.geom_bad) begin
               state_in = S_FAIL;
            end else begin
               cmd.div_go  = 1'b1;
               cmd.div_sel = DIV_SPC;
               state_in    = S_LOC_SPC_WAIT;
            end
         end
         S_LOC_SPC_WAIT: begin
            if (!sts.div_busy) begin
               // no whole sector fits in a chip
               if (sts.quot_zero) begin
                  state_in = S_FAIL;
               end else begin
                  cmd.spc_load = 1'b1;
                  cmd.mul_go   = 1'b1;
                  cmd.mul_sel  = MUL_OFFSET;
                  state_in     = S_LOC_CHIP;
               end
            end
         end
         S_LOC_CHIP: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_CHIP;
            state_in    = S_LOC_CHIP_WAIT;
         end
         S_LOC_CHIP_WAIT: begin
            cmd.div_sel = DIV_CHIP;
            if (!sts.div_busy) begin
               if (sts.chip_out) begin
                  state_in = S_FAIL;
               end else begin
                  cmd.chip_load = 1'b1;
                  cmd.div_go    = 1'b1;
                  cmd.div_sel   = DIV_OFFSET;
                  state_in      = S_LOC_OFF_WAIT;
               end
            end
         end
         S_LOC_OFF_WAIT: begin
            cmd.div_sel = DIV_OFFSET;
            if (!sts.div_busy) begin
               cmd.off_load = 1'b1;
               cmd.set_busy = 1'b1;
               state_in     = S_HDR;
            end
         end
         S_HDR: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.res_kind = RES_HDR;
               cmd.res_last = sts.hdr_last;
               cmd.hdr_dec  = 1'b1;
               if (sts.hdr_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FAIL: begin
            // drop the transfer and report the bad geometry or out-of-range chip
            if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.res_status = ST_PARAM;
               cmd.res_last   = 1'b1;
               cmd.clr_busy   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

endmodule

// ===== sv/spi_sram_sector_bank_controller_core.sv =====
// ----------------------------------------------------------------------------
// SPI SRAM sector bank controller core
// Maps sector read and write requests onto SPI byte beats for a bank of
// serial SRAM chips; answers init, ioctl and error cases with status beats.
// ----------------------------------------------------------------------------
// Simple items (a data byte inside a sector, init, status answers, simple ioctl
//   queries) are answered through the result register; no new item is taken
//   until the controller is back in idle.
// Sector start: three shared 1-bit-per-cycle divider passes set chip and offset,
//   then 1 + (ADDR_BITS+7)/8 header beats, one per cycle while the output is free.
// Sector count query: one divider pass.
// Reset: synchronous; config returns to its defaults, the bank is not ready
//   and idle. No clearing pass.
module spi_sram_sector_bank_controller_core #(
   parameter int MAX_CHIPS = ssbc_pkg::MAX_CHIPS_DEF,
   parameter int ADDR_BITS = ssbc_pkg::ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // start_sector, sector_count, data_byte, ioctl_cmd, zero fill
   input  logic [ssbc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  logic [ssbc_pkg::FUNC_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // spi_byte, spi_valid, chip_index, select_active, read_byte, read_valid,
   // status, info_value, zero fill
   output logic [ssbc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [ssbc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ssbc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssbc_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;
   rsp_data_type rsp_view;

   ssbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ssbc_dp #(
      .MAX_CHIPS (MAX_CHIPS),
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   assign rsp_view = rsp_data_type'(rsp_tdata);

   a_read_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.read_valid |->
         rsp_view.spi_valid && (rsp_view.spi_byte == FILL_BYTE))
      else $error("read beat without fill byte on the bus");

   a_error_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_view.status != ST_OK) |-> rsp_tlast && !rsp_view.spi_valid)
      else $error("error status on a bus beat or before the final beat");

   a_div_in_item: assert property (@(posedge clock) disable iff (reset)
      sts.div_busy |-> !req_tready)
      else $error("divider running while the request side is open");

   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken before the first was decoded");

endmodule
